@@ sv/ehtcap_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ehtcap_pkg;

  // Section codes of a result
  localparam logic [2:0] SEC_MAC   = 3'd0;
  localparam logic [2:0] SEC_PHY   = 3'd1;
  localparam logic [2:0] SEC_EXTRA = 3'd2;
  localparam logic [2:0] SEC_MAP   = 3'd3;
  localparam logic [2:0] SEC_PPE   = 3'd4;
  localparam logic [2:0] SEC_PAIR  = 3'd5;

  // MCS/NSS map kinds; NO_MAP marks that no further map is present
  localparam logic [2:0] MAP_20    = 3'd0;
  localparam logic [2:0] MAP_80    = 3'd1;
  localparam logic [2:0] MAP_160   = 3'd2;
  localparam logic [2:0] MAP_320   = 3'd3;
  localparam logic [2:0] NO_MAP    = 3'd4;
  localparam int         MAP_KINDS = 4;

  // Register indexes of the configuration port
  localparam logic REG_BAND  = 1'b0;
  localparam logic REG_WIDTH = 1'b1;

  // Channel width set bits that rule out the 20 MHz-only map
  localparam logic [6:0] WIDTH_ABOVE_20 = 7'h0e;

  // Result queue depth
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

  typedef struct packed {
    logic       band_is_2_4ghz;
    logic [6:0] he_width_set;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  section;
    logic [1:0]  map_type;
    logic [63:0] field_value;
    logic [6:0]  pair_index;
    logic [2:0]  ppet_max;
    logic [2:0]  ppet_eight;
    logic        last_in_run;
    logic        end_of_element;
  } result_t;

endpackage

`default_nettype wire

@@ sv/eht_capabilities_element_parser_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake              Payload
// input     in_valid / in_ready    data_byte, start_element
// output    out_valid / out_ready  section, map_type, field_value, pair_index,
//                                  ppet_max, ppet_eight, last_in_run, end_of_element
// config    APB psel/penable       paddr, pwdata, prdata (pready tied high)
//
// One byte is taken per cycle while in_ready is high; its results are registered
// in the result queue. A byte yields zero, one or two results; the output drains
// one result per cycle while out_ready is high, so two-result bytes are paced by
// the output. The four-entry result queue sets the stall: in_ready drops while it
// holds more than two results. Synchronous reset returns the parser to idle and
// empties the queue; the registers reset to zero.

module eht_capabilities_element_parser_unit (
  input  wire         clk,
  input  wire         rst,
  // input channel
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [7:0]  data_byte,
  input  wire         start_element,
  // output channel
  output logic        out_valid,
  input  wire         out_ready,
  output logic [2:0]  section,
  output logic [1:0]  map_type,
  output logic [63:0] field_value,
  output logic [6:0]  pair_index,
  output logic [2:0]  ppet_max,
  output logic [2:0]  ppet_eight,
  output logic        last_in_run,
  output logic        end_of_element,
  // configuration port
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  ehtcap_pkg::cfg_t    cfg;
  ehtcap_pkg::result_t res0, res1, head;
  logic [1:0]          res_n;
  logic                in_fire;
  logic                pop;
  logic                room2;
  logic                wr_en;

  // Configuration registers
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (paddr[2])
        ehtcap_pkg::REG_BAND:  cfg.band_is_2_4ghz <= pwdata[0];
        ehtcap_pkg::REG_WIDTH: cfg.he_width_set   <= pwdata[6:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      ehtcap_pkg::REG_BAND:  prdata = {31'b0, cfg.band_is_2_4ghz};
      ehtcap_pkg::REG_WIDTH: prdata = {25'b0, cfg.he_width_set};
    endcase
  end

  // Accept a request while the queue can take two results
  assign in_ready = room2;
  assign in_fire  = in_valid && in_ready;
  assign pop      = out_valid && out_ready;

  ehtcap_parse u_parse (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_fire       (in_fire),
    .data_byte     (data_byte),
    .start_element (start_element),
    .res_n         (res_n),
    .res0          (res0),
    .res1          (res1)
  );

  ehtcap_rfifo u_rfifo (
    .clk        (clk),
    .rst        (rst),
    .push_n     (res_n),
    .push0      (res0),
    .push1      (res1),
    .pop        (pop),
    .head_valid (out_valid),
    .head       (head),
    .room2      (room2)
  );

  // Drive the result fields from the queue head
  assign section        = head.section;
  assign map_type       = head.map_type;
  assign field_value    = head.field_value;
  assign pair_index     = head.pair_index;
  assign ppet_max       = head.ppet_max;
  assign ppet_eight     = head.ppet_eight;
  assign last_in_run    = head.last_in_run;
  assign end_of_element = head.end_of_element;

endmodule

`default_nettype wire

@@ sv/ehtcap_parse.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ehtcap_parse (
  input  wire                     clk,
  input  wire                     rst,
  input  ehtcap_pkg::cfg_t        cfg,
  input  wire                     in_fire,
  input  wire  [7:0]              data_byte,
  input  wire                     start_element,
  output logic [1:0]              res_n,
  output ehtcap_pkg::result_t     res0,
  output ehtcap_pkg::result_t     res1
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MAC   = 3'd1;
  localparam logic [2:0] ST_PHY   = 3'd2;
  localparam logic [2:0] ST_EXTRA = 3'd3;
  localparam logic [2:0] ST_MAP   = 3'd4;
  localparam logic [2:0] ST_PPE1  = 3'd5;
  localparam logic [2:0] ST_PPE2  = 3'd6;
  localparam logic [2:0] ST_PAIRS = 3'd7;

  // Parser state
  logic [2:0]  state, state_next;
  logic [3:0]  bis, bis_next;
  logic [63:0] aw, aw_next;
  logic        w320, w320_next;
  logic        ppe, ppe_next;
  logic [2:0]  nmk, nmk_next;
  logic [7:0]  resv, resv_next;
  logic [3:0]  rcnt, rcnt_next;
  logic [6:0]  pleft, pleft_next;
  logic [6:0]  pcnt, pcnt_next;

  // State as seen by this byte (a start marker restarts the element)
  logic [2:0]  st_e;
  logic [3:0]  bis_e;
  logic [63:0] aw_e;
  logic        w320_e, ppe_e;
  logic [2:0]  nmk_e;
  logic [7:0]  resv_e;
  logic [3:0]  rcnt_e;
  logic [6:0]  pleft_e, pcnt_e;

  // Working values
  logic [3:0]  len;
  logic [63:0] aw_acc;
  logic [3:0]  bis_inc;
  logic [3:0]  wanted;
  logic [3:0]  avail;
  logic [2:0]  from;
  logic [2:0]  found;
  logic        adv_end;
  logic [2:0]  adv_state;
  logic [3:0]  nss;
  logic [4:0]  ru;
  logic [2:0]  ones;
  logic [7:0]  prod;
  logic [15:0] bits0, bits1, bits2;
  logic [3:0]  cnt0, cnt1, cnt2;
  logic [6:0]  pl0, pl1, pl2;
  logic [6:0]  pc0, pc1, pc2;
  logic        take_a, take_b;
  ehtcap_pkg::result_t pair_a, pair_b;
  ehtcap_pkg::result_t r0, r1;
  logic [1:0]  n;

  // Restart on a start marker
  always_comb begin
    if (start_element) begin
      st_e    = ST_MAC;
      bis_e   = '0;
      aw_e    = '0;
      w320_e  = 1'b0;
      ppe_e   = 1'b0;
      nmk_e   = '0;
      resv_e  = '0;
      rcnt_e  = '0;
      pleft_e = '0;
      pcnt_e  = '0;
    end else begin
      st_e    = state;
      bis_e   = bis;
      aw_e    = aw;
      w320_e  = w320;
      ppe_e   = ppe;
      nmk_e   = nmk;
      resv_e  = resv;
      rcnt_e  = rcnt;
      pleft_e = pleft;
      pcnt_e  = pcnt;
    end
  end

  // Pick the next wanted map from the band and channel width set
  always_comb begin
    if (cfg.band_is_2_4ghz) begin
      wanted = {2'b00, cfg.he_width_set[0], ~cfg.he_width_set[0]};
    end else begin
      wanted = {w320_e, cfg.he_width_set[2], cfg.he_width_set[1],
                (cfg.he_width_set & ehtcap_pkg::WIDTH_ABOVE_20) == 7'd0};
    end
    from = (st_e == ST_MAP) ? ({1'b0, nmk_e[1:0]} + 3'd1) : 3'd0;
    for (int i = 0; i < ehtcap_pkg::MAP_KINDS; i++) begin
      avail[i] = wanted[i] && (3'(i) >= from);
    end
    found = ehtcap_pkg::NO_MAP;
    for (int i = ehtcap_pkg::MAP_KINDS - 1; i >= 0; i--) begin
      if (avail[i]) begin
        found = 3'(i);
      end
    end
    adv_end = (found == ehtcap_pkg::NO_MAP) && !ppe_e;
    if (found != ehtcap_pkg::NO_MAP) begin
      adv_state = ST_MAP;
    end else if (ppe_e) begin
      adv_state = ST_PPE1;
    end else begin
      adv_state = ST_IDLE;
    end
  end

  // PPE header fields and pair count
  always_comb begin
    nss  = aw_e[3:0];
    ru   = {data_byte[0], aw_e[7:4]};
    ones = '0;
    for (int j = 0; j < 5; j++) begin
      ones = ones + {2'b00, ru[j]};
    end
    prod = {5'b0, ones} * {3'b0, {1'b0, nss} + 5'd1};
  end

  // Extract up to two threshold pairs from the bit reservoir and this byte
  always_comb begin
    if (st_e == ST_PPE2) begin
      bits0 = {9'b0, data_byte[7:1]};
      cnt0  = 4'd7;
      pl0   = prod[6:0];
      pc0   = '0;
    end else begin
      bits0 = {8'b0, resv_e} | ({8'b0, data_byte} << rcnt_e[2:0]);
      cnt0  = {1'b0, rcnt_e[2:0]} + 4'd8;
      pl0   = pleft_e;
      pc0   = pcnt_e;
    end

    take_a = (cnt0 >= 4'd6) && (pl0 != 7'd0);
    pair_a = '0;
    pair_a.section        = ehtcap_pkg::SEC_PAIR;
    pair_a.pair_index     = pc0;
    pair_a.ppet_max       = bits0[2:0];
    pair_a.ppet_eight     = bits0[5:3];
    pair_a.end_of_element = (pl0 == 7'd1);
    pl1   = take_a ? pl0 - 7'd1 : pl0;
    pc1   = take_a ? pc0 + 7'd1 : pc0;
    bits1 = take_a ? bits0 >> 6 : bits0;
    cnt1  = take_a ? cnt0 - 4'd6 : cnt0;

    take_b = (st_e == ST_PAIRS) && (cnt1 >= 4'd6) && (pl1 != 7'd0);
    pair_b = '0;
    pair_b.section        = ehtcap_pkg::SEC_PAIR;
    pair_b.pair_index     = pc1;
    pair_b.ppet_max       = bits1[2:0];
    pair_b.ppet_eight     = bits1[5:3];
    pair_b.end_of_element = (pl1 == 7'd1);
    pl2   = take_b ? pl1 - 7'd1 : pl1;
    pc2   = take_b ? pc1 + 7'd1 : pc1;
    bits2 = take_b ? bits1 >> 6 : bits1;
    cnt2  = take_b ? cnt1 - 4'd6 : cnt1;
  end

  // Byte assembly for the multi-byte words
  always_comb begin
    if (st_e == ST_MAC) begin
      len = 4'd2;
    end else if (st_e == ST_PHY) begin
      len = 4'd8;
    end else if (nmk_e == ehtcap_pkg::MAP_20) begin
      len = 4'd4;
    end else begin
      len = 4'd3;
    end
    aw_acc  = aw_e | ({56'b0, data_byte} << {bis_e[2:0], 3'b000});
    bis_inc = bis_e + 4'd1;
  end

  // Section sequencer
  always_comb begin
    state_next = st_e;
    bis_next   = bis_e;
    aw_next    = aw_e;
    w320_next  = w320_e;
    ppe_next   = ppe_e;
    nmk_next   = nmk_e;
    resv_next  = resv_e;
    rcnt_next  = rcnt_e;
    pleft_next = pleft_e;
    pcnt_next  = pcnt_e;
    r0 = '0;
    r1 = '0;
    n  = 2'd0;

    unique case (st_e)
      ST_IDLE: begin
      end
      ST_MAC, ST_PHY, ST_MAP: begin
        if (bis_inc >= len) begin
          bis_next = '0;
          aw_next  = '0;
          n        = 2'd1;
          if (st_e == ST_MAC) begin
            r0.section     = ehtcap_pkg::SEC_MAC;
            r0.field_value = {55'b0, aw_acc[8:0]};
            state_next     = ST_PHY;
          end else if (st_e == ST_PHY) begin
            r0.section     = ehtcap_pkg::SEC_PHY;
            r0.field_value = {aw_acc[63:1], 1'b0};
            w320_next      = aw_acc[1];
            ppe_next       = aw_acc[43];
            state_next     = ST_EXTRA;
          end else begin
            r0.section        = ehtcap_pkg::SEC_MAP;
            r0.map_type       = nmk_e[1:0];
            r0.field_value    = aw_acc;
            r0.end_of_element = adv_end;
            state_next        = adv_state;
            if (found != ehtcap_pkg::NO_MAP) begin
              nmk_next = found;
            end
          end
        end else begin
          bis_next = bis_inc;
          aw_next  = aw_acc;
        end
      end
      ST_EXTRA: begin
        r0.section        = ehtcap_pkg::SEC_EXTRA;
        r0.field_value    = {62'b0, data_byte[1:0]};
        r0.end_of_element = adv_end;
        n          = 2'd1;
        bis_next   = '0;
        aw_next    = '0;
        state_next = adv_state;
        if (found != ehtcap_pkg::NO_MAP) begin
          nmk_next = found;
        end
      end
      ST_PPE1: begin
        aw_next    = {56'b0, data_byte};
        state_next = ST_PPE2;
      end
      ST_PPE2, ST_PAIRS: begin
        aw_next    = '0;
        pleft_next = pl2;
        pcnt_next  = pc2;
        if (pl2 == 7'd0) begin
          state_next = ST_IDLE;
          resv_next  = '0;
          rcnt_next  = '0;
        end else begin
          state_next = ST_PAIRS;
          resv_next  = bits2[7:0];
          rcnt_next  = cnt2;
        end
        if (st_e == ST_PPE2) begin
          r0.section        = ehtcap_pkg::SEC_PPE;
          r0.field_value    = {55'b0, ru, nss};
          r0.end_of_element = (pl0 == 7'd0);
          r1 = pair_a;
          n  = take_a ? 2'd2 : 2'd1;
        end else begin
          r0 = pair_a;
          r1 = pair_b;
          n  = {1'b0, take_a} + {1'b0, take_b};
        end
      end
    endcase

    // Mark the last result of this byte
    if (n == 2'd1) begin
      r0.last_in_run = 1'b1;
    end else if (n == 2'd2) begin
      r1.last_in_run = 1'b1;
    end
  end

  assign res_n = in_fire ? n : 2'd0;
  assign res0  = r0;
  assign res1  = r1;

  // Advance the state on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      bis   <= '0;
      aw    <= '0;
      w320  <= 1'b0;
      ppe   <= 1'b0;
      nmk   <= '0;
      resv  <= '0;
      rcnt  <= '0;
      pleft <= '0;
      pcnt  <= '0;
    end else if (in_fire) begin
      state <= state_next;
      bis   <= bis_next;
      aw    <= aw_next;
      w320  <= w320_next;
      ppe   <= ppe_next;
      nmk   <= nmk_next;
      resv  <= resv_next;
      rcnt  <= rcnt_next;
      pleft <= pleft_next;
      pcnt  <= pcnt_next;
    end
  end

  // The pair section always has pairs outstanding
  a_pairs_left: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PAIRS) |-> (pleft != 7'd0))
    else $error("pair section entered with no pairs left");

  // The reservoir never holds a whole pair between bytes
  a_reservoir: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PAIRS) |-> (rcnt < 4'd6))
    else $error("reservoir holds a full pair");

  // The byte index stays inside the two-byte MAC word
  a_mac_index: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MAC) |-> (bis < 4'd2))
    else $error("mac byte index out of range");

endmodule

`default_nettype wire

@@ sv/ehtcap_rfifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ehtcap_rfifo (
  input  wire                     clk,
  input  wire                     rst,
  input  wire  [1:0]              push_n,
  input  ehtcap_pkg::result_t     push0,
  input  ehtcap_pkg::result_t     push1,
  input  wire                     pop,
  output logic                    head_valid,
  output ehtcap_pkg::result_t     head,
  output logic                    room2
);

  localparam int PW = ehtcap_pkg::RES_PTR_W;
  localparam int CW = ehtcap_pkg::RES_CNT_W;

  ehtcap_pkg::result_t entries [ehtcap_pkg::RES_DEPTH];
  logic [PW-1:0] rd_ptr, wr_ptr;
  logic [CW-1:0] count, count_next;

  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign room2      = (count <= CW'(ehtcap_pkg::RES_DEPTH - 2));
  assign count_next = count + CW'(push_n) - CW'(pop);

  // Store new results
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      entries[wr_ptr] <= push0;
    end
    if (push_n == 2'd2) begin
      entries[wr_ptr + PW'(1)] <= push1;
    end
  end

  // Advance the pointers and the fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push_n);
      rd_ptr <= rd_ptr + PW'(pop);
      count  <= count_next;
    end
  end

  // Never pop an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("result queue underflow");

  // Never push past the depth
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push_n != 2'd0) |-> ({1'b0, count} + (CW + 1)'(push_n)
                          <= (CW + 1)'(ehtcap_pkg::RES_DEPTH) + (CW + 1)'(pop)))
    else $error("result queue overflow");

endmodule

`default_nettype wire
